>>> src/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

    // Request action codes
    localparam logic [2:0] ACT_GET    = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_APPEND = 3'd2;
    localparam logic [2:0] ACT_DELETE = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  index;
        logic [31:0] value;
    } ils_req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] read_value;
        logic [5:0]  entry_count;
        logic        is_empty;
    } ils_rsp_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] value;
    } cell_cmd_t;

endpackage

>>> src/ils_cell.sv
`timescale 1ns / 1ps

module ils_cell #(
    parameter int POS        = 0,
    parameter int PW         = 6,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  ils_pkg::cell_cmd_t    cmd,
    input  logic [PW-1:0]         target,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic [VALUE_BITS-1:0] right_value,
    output logic [VALUE_BITS-1:0] cell_value,
    output logic [31:0]           read_out
);
    import ils_pkg::*;

    localparam logic [PW-1:0] MY_POS = PW'(POS);

    logic [VALUE_BITS-1:0] data_reg;
    logic [VALUE_BITS-1:0] data_next;
    logic                  hit;
    logic                  above;

    assign hit   = (target == MY_POS);
    assign above = (MY_POS > target);

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                // take the new value at the gap, shift the tail one slot back
                if (hit)
                    data_next = VALUE_BITS'(cmd.value);
                else if (above)
                    data_next = left_value;
            end
            CELL_DELETE:
            begin
                // close the gap by pulling from the right neighbor
                if (hit || above)
                    data_next = right_value;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign cell_value = data_reg;
    assign read_out   = hit ? 32'(data_reg) : 32'd0;

endmodule

>>> src/indexed_list_store.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload               Direction
// -------   ---------             -------               ---------
// request   start high, busy low  request (ils_req_t)   in
// result    done strobe           result  (ils_rsp_t)   out
//
// One request per cycle: busy stays low, the result of a request taken at
// one edge is shown with done for exactly the next cycle.
// The figure is set by the cell chain, which shifts, loads or reads every
// slot in the same edge that updates the entry count register.
// Reset empties the list (count to zero); cell contents are left as they are.
// The receiver cannot stall; done marks a result for a single cycle.

module indexed_list_store #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ils_pkg::ils_req_t request,
    output logic              done,
    output ils_pkg::ils_rsp_t result
);
    import ils_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            done_reg;
    ils_rsp_t        result_reg;
    ils_rsp_t        result_next;

    logic            accept;
    logic [CMPW-1:0] idx_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            in_range;
    logic            full;
    logic            ok;
    cell_cmd_t       cmd;
    logic [CW-1:0]   target;
    logic [31:0]     read_bus;

    logic [VALUE_BITS-1:0] cell_values [CAPACITY];
    logic [31:0]           cell_reads  [CAPACITY];

    // The chain finishes every action in the cycle it is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign idx_ext  = CMPW'(request.index);
    assign cnt_ext  = CMPW'(count_reg);
    assign in_range = (idx_ext < cnt_ext);
    assign full     = (count_reg == FULL_COUNT);

    // Decode the request into a cell command and the next count.
    always_comb
    begin
        ok         = 1'b0;
        cmd.op     = CELL_HOLD;
        cmd.value  = request.value;
        target     = CW'(idx_ext);
        count_next = count_reg;
        unique case (request.action)
            ACT_GET:
            begin
                ok = in_range;
            end
            ACT_INSERT:
            begin
                ok = !full && ((request.index == 6'd0) || in_range);
                if (ok)
                begin
                    cmd.op     = CELL_INSERT;
                    count_next = count_reg + ONE_COUNT;
                end
            end
            ACT_APPEND:
            begin
                ok     = !full;
                target = count_reg;
                if (ok)
                begin
                    cmd.op     = CELL_INSERT;
                    count_next = count_reg + ONE_COUNT;
                end
            end
            ACT_DELETE:
            begin
                ok = in_range;
                if (ok)
                begin
                    cmd.op     = CELL_DELETE;
                    count_next = count_reg - ONE_COUNT;
                end
            end
            ACT_CLEAR:
            begin
                ok         = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        // Hold every cell unless a request is actually taken.
        if (!accept)
        begin
            cmd.op     = CELL_HOLD;
            count_next = count_reg;
        end
    end

    // Row of cells: each hands its value to its neighbors every cycle.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] left_v;
        logic [VALUE_BITS-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = cell_values[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_mid_r
            assign right_v = cell_values[i+1];
        end

        ils_cell #(
            .POS        (i),
            .PW         (CW),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .target      (target),
            .left_value  (left_v),
            .right_value (right_v),
            .cell_value  (cell_values[i]),
            .read_out    (cell_reads[i])
        );
    end

    // Only the addressed cell drives a nonzero word onto the read bus.
    always_comb
    begin
        read_bus = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            read_bus = read_bus | cell_reads[k];
        end
    end

    always_comb
    begin
        result_next.status      = !ok;
        result_next.read_value  = (ok && (request.action == ACT_GET)) ? read_bus : 32'd0;
        result_next.entry_count = 6'(count_next);
        result_next.is_empty    = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result payload needs no reset; done qualifies it.
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above capacity");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("taken request gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without a request");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (count_reg == '0)))
        else $error("empty flag disagrees with count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.read_value == 32'd0))
        else $error("failed request returned data");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ils_pkg::*;

    // Shadow copy of the list plus the queue of results the block owes.
    class list_shadow;
        int unsigned     capacity;
        logic [31:0]     slots[$];
        ils_rsp_t        expected_results[$];
        int unsigned     errors;
        int unsigned     requests_seen;
        int unsigned     results_checked;
        int unsigned     full_refusals;
        int unsigned     times_emptied;
        int unsigned     deepest;

        function new(int unsigned cap);
            capacity        = cap;
            errors          = 0;
            requests_seen   = 0;
            results_checked = 0;
            full_refusals   = 0;
            times_emptied   = 0;
            deepest         = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // Apply one accepted request to the shadow list and queue its result.
        function void take_request(ils_req_t req);
            ils_rsp_t    rsp;
            int unsigned n;
            rsp        = '0;
            rsp.status = 1'b1;
            n          = slots.size();
            case (req.action)
                ACT_GET:
                    if (req.index < n)
                    begin
                        rsp.read_value = slots[req.index];
                        rsp.status     = 1'b0;
                    end
                ACT_INSERT:
                    if (n < capacity && (req.index == 0 || req.index < n))
                    begin
                        slots.insert(req.index, req.value);
                        rsp.status = 1'b0;
                    end
                    else if (n == capacity)
                    begin
                        full_refusals++;
                    end
                ACT_APPEND:
                    if (n < capacity)
                    begin
                        slots.push_back(req.value);
                        rsp.status = 1'b0;
                    end
                    else
                    begin
                        full_refusals++;
                    end
                ACT_DELETE:
                    if (req.index < n)
                    begin
                        slots.delete(req.index);
                        rsp.status = 1'b0;
                        if (slots.size() == 0)
                            times_emptied++;
                    end
                ACT_CLEAR:
                    begin
                        slots.delete();
                        rsp.status = 1'b0;
                        times_emptied++;
                    end
                default:
                    ;
            endcase
            rsp.entry_count = 6'(slots.size());
            rsp.is_empty    = (slots.size() == 0);
            if (slots.size() > deepest)
                deepest = slots.size();
            expected_results.push_back(rsp);
            requests_seen++;
        endfunction

        // Compare one result, field by field, with the oldest expectation.
        function void match_result(ils_rsp_t rsp);
            ils_rsp_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no request waiting: %h", $time, rsp);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (rsp.status !== want.status)
            begin
                $display("%0t: status expected %h actual %h",
                         $time, want.status, rsp.status);
                errors++;
            end
            if (rsp.read_value !== want.read_value)
            begin
                $display("%0t: read_value expected %h actual %h",
                         $time, want.read_value, rsp.read_value);
                errors++;
            end
            if (rsp.entry_count !== want.entry_count)
            begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.entry_count, rsp.entry_count);
                errors++;
            end
            if (rsp.is_empty !== want.is_empty)
            begin
                $display("%0t: is_empty expected %h actual %h",
                         $time, want.is_empty, rsp.is_empty);
                errors++;
            end
        endfunction
    endclass

    localparam int unsigned CAPACITY     = 32;
    localparam int unsigned PHASES       = 13;
    localparam int unsigned PHASE_ITEMS  = 150;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE       = 4;

    // Action codes the block treats as undefined
    localparam logic [2:0] ACT_UNDEF_LO = ACT_CLEAR + 3'd1;
    localparam logic [2:0] ACT_UNDEF_HI = 3'b111;

    // Steering of the random part: grow toward full, drain toward empty,
    // an even mix, or a noisy mix heavy on clears and undefined codes.
    typedef enum logic [1:0] {
        MODE_GROW,
        MODE_MIXED,
        MODE_SHRINK,
        MODE_NOISE
    } phase_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    ils_req_t    request;
    ils_rsp_t    result;
    int unsigned cycles = 0;

    list_shadow  shadow;

    indexed_list_store #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (32)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    // Stop a hung run: nothing correct comes close to this many cycles.
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Sample at the rising edge: check the strobed result first, then note
    // the request taken at this same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                shadow.match_result(result);
            if (start && !busy)
                shadow.take_request(request);
        end
    end

    // Hold start low for the gap, then present the request and hold it until
    // an edge with busy low takes it. Leave start high on return: the next
    // call either replaces the request or drops start at the next falling edge.
    task automatic send_request(ils_req_t req, int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and wait until every owed result has come back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
    endtask

    function automatic ils_req_t make_request(logic [2:0] act, logic [5:0] idx,
                                              logic [31:0] val);
        ils_req_t r;
        r.action = act;
        r.index  = idx;
        r.value  = val;
        return r;
    endfunction

    function automatic logic [2:0] pick_action(phase_mode_t mode);
        int unsigned roll;
        int unsigned w_ins, w_app, w_get, w_del, w_clr;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
            begin
                w_ins = 32; w_app = 35; w_get = 15; w_del = 14; w_clr = 2;
            end
            MODE_SHRINK:
            begin
                w_ins = 10; w_app = 10; w_get = 20; w_del = 55; w_clr = 2;
            end
            MODE_MIXED:
            begin
                w_ins = 22; w_app = 18; w_get = 30; w_del = 25; w_clr = 2;
            end
            default:
            begin
                w_ins = 15; w_app = 15; w_get = 20; w_del = 20; w_clr = 10;
            end
        endcase
        if (roll < w_ins)
            return ACT_INSERT;
        roll -= w_ins;
        if (roll < w_app)
            return ACT_APPEND;
        roll -= w_app;
        if (roll < w_get)
            return ACT_GET;
        roll -= w_get;
        if (roll < w_del)
            return ACT_DELETE;
        roll -= w_del;
        if (roll < w_clr)
            return ACT_CLEAR;
        return 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
    endfunction

    // Aim most indexes inside the list, some at its edges, the rest anywhere.
    // The shadow count may lag the block by one request here; that only
    // blurs the steering, never the checking.
    function automatic ils_req_t random_request(phase_mode_t mode);
        int unsigned n;
        int unsigned roll;
        logic [5:0]  idx;
        logic [31:0] val;
        n    = shadow.slots.size();
        roll = $urandom_range(0, 99);
        if (roll < 60)
            idx = 6'($urandom_range(0, (n > 0) ? n - 1 : 0));
        else if (roll < 70)
            idx = 6'(n);
        else if (roll < 78)
            idx = (n > 0) ? 6'(n - 1) : 6'd0;
        else
            idx = 6'($urandom_range(0, 63));
        roll = $urandom_range(0, 99);
        if (roll < 8)
            val = '0;
        else if (roll < 16)
            val = '1;
        else
            val = $urandom;
        return make_request(pick_action(mode), idx, val);
    endfunction

    // Short directed opener: empty-list refusals, insert at the front of an
    // empty list, insert before an entry, inserts at and past the end,
    // out-of-range get and delete, front and back deletes, undefined codes,
    // clear and reuse after clear, with the value extremes.
    task automatic run_directed();
        ils_req_t plan[$];
        plan.push_back(make_request(ACT_GET,    6'd0,  32'h0));
        plan.push_back(make_request(ACT_GET,    6'd63, 32'h0));
        plan.push_back(make_request(ACT_DELETE, 6'd0,  32'h0));
        plan.push_back(make_request(ACT_INSERT, 6'd5,  32'hDEAD_BEEF));
        plan.push_back(make_request(ACT_INSERT, 6'd0,  32'h0000_0000));
        plan.push_back(make_request(ACT_APPEND, 6'd63, 32'hFFFF_FFFF));
        plan.push_back(make_request(ACT_APPEND, 6'd0,  32'hA5A5_5A5A));
        plan.push_back(make_request(ACT_INSERT, 6'd1,  32'h1234_5678));
        plan.push_back(make_request(ACT_INSERT, 6'd4,  32'h1111_1111));
        plan.push_back(make_request(ACT_INSERT, 6'd63, 32'h2222_2222));
        plan.push_back(make_request(ACT_GET,    6'd0,  32'hFFFF_FFFF));
        plan.push_back(make_request(ACT_GET,    6'd1,  32'h0));
        plan.push_back(make_request(ACT_GET,    6'd2,  32'h0));
        plan.push_back(make_request(ACT_GET,    6'd3,  32'h0));
        plan.push_back(make_request(ACT_GET,    6'd4,  32'h0));
        plan.push_back(make_request(ACT_DELETE, 6'd63, 32'h0));
        plan.push_back(make_request(ACT_DELETE, 6'd3,  32'h0));
        plan.push_back(make_request(ACT_DELETE, 6'd0,  32'h0));
        plan.push_back(make_request(ACT_UNDEF_LO,        6'd0,  32'hFFFF_FFFF));
        plan.push_back(make_request(ACT_UNDEF_LO + 3'd1, 6'd1,  32'h0));
        plan.push_back(make_request(ACT_UNDEF_HI,        6'd63, 32'h5555_AAAA));
        plan.push_back(make_request(ACT_CLEAR,  6'd63, 32'hFFFF_FFFF));
        plan.push_back(make_request(ACT_GET,    6'd0,  32'h0));
        plan.push_back(make_request(ACT_INSERT, 6'd0,  32'h8000_0001));
        plan.push_back(make_request(ACT_DELETE, 6'd0,  32'h0));
        foreach (plan[i])
            send_request(plan[i], $urandom_range(0, 7));
    endtask

    initial
    begin
        phase_mode_t mode;
        bit          no_gaps;
        // Drive every input known from time zero and start in reset.
        shadow  = new(CAPACITY);
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        // Pause the sender until the block has answered everything.
        drain_results();

        for (int unsigned p = 0; p < PHASES; p++)
        begin
            mode    = phase_mode_t'(p % 4);
            no_gaps = (p % 3 == 2);
            for (int unsigned k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request(mode), no_gaps ? 0 : $urandom_range(0, 7));
            if (p % 2 == 1)
                drain_results();
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);

        if (shadow.pending() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, shadow.pending());
            shadow.errors++;
        end

        $display("covered %0d requests, %0d results checked, %0d mismatches",
                 shadow.requests_seen, shadow.results_checked, shadow.errors);
        $display("deepest list %0d of %0d, %0d refusals when full, emptied %0d times",
                 shadow.deepest, CAPACITY, shadow.full_refusals, shadow.times_emptied);
        if (shadow.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
